// ----- hw/rtl/slip_rx_pkg.sv -----
// shared types and constants for the slip receive deframer
// no dependencies; used by every other file of the block
package slip_rx_pkg;

  // field and register widths
  localparam int BYTE_WIDTH = 8;
  localparam int CFG_WIDTH = 12;
  localparam int POS_WIDTH = 12;
  localparam int INDEX_WIDTH = 1;
  localparam int LENGTH_BITS_DEFAULT = 12;

  // slip special characters
  localparam logic [BYTE_WIDTH-1:0] FRAME_END_CODE = 8'hC0;
  localparam logic [BYTE_WIDTH-1:0] ESCAPE_CODE = 8'hDB;
  localparam logic [BYTE_WIDTH-1:0] ESCAPED_END_CODE = 8'hDC;
  localparam logic [BYTE_WIDTH-1:0] ESCAPED_ESCAPE_CODE = 8'hDD;

  // configuration register indexes and reset values
  localparam logic [INDEX_WIDTH-1:0] REG_PAYLOAD_CAPACITY = 1'b0;
  localparam logic [INDEX_WIDTH-1:0] REG_MAX_TRANSFER_UNIT = 1'b1;
  localparam logic [CFG_WIDTH-1:0] PAYLOAD_CAPACITY_RESET = 12'd1500;
  localparam logic [CFG_WIDTH-1:0] MAX_TRANSFER_UNIT_RESET = 12'd1500;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_DATA = 2'd0,
    STATUS_GOOD = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_TOO_LONG = 2'd3
  } status_t;

  // one decoded result
  typedef struct packed {
    logic [BYTE_WIDTH-1:0] data_byte;
    logic [POS_WIDTH-1:0] byte_position;
    logic frame_end;
    status_t frame_status;
  } result_t;

endpackage

// ----- hw/rtl/slip_rx_if.sv -----
// valid/ready channel interfaces for raw bytes and decoded results
// depends on slip_rx_pkg for field widths
interface slip_rx_byte_if;
  logic valid;
  logic ready;
  logic [slip_rx_pkg::BYTE_WIDTH-1:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

interface slip_rx_result_if;
  logic valid;
  logic ready;
  logic [slip_rx_pkg::BYTE_WIDTH-1:0] data_byte;
  logic [slip_rx_pkg::POS_WIDTH-1:0] byte_position;
  logic frame_end;
  logic [1:0] frame_status;

  modport source (output valid, output data_byte, output byte_position,
                  output frame_end, output frame_status, input ready);
  modport sink (input valid, input data_byte, input byte_position,
                input frame_end, input frame_status, output ready);
endinterface

// ----- hw/rtl/slip_rx_in_stage.sv -----
// input register: holds one raw byte until the decode stage takes it
// depends on slip_rx_pkg
module slip_rx_in_stage (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [slip_rx_pkg::BYTE_WIDTH-1:0] in_byte,
  input  logic take,
  output logic advance,
  output logic [slip_rx_pkg::BYTE_WIDTH-1:0] held_byte
);

  logic held_valid;

  // the held byte moves on when the result side can take it
  assign advance = held_valid && take;
  assign in_ready = !held_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

endmodule

// ----- hw/rtl/slip_rx_decode.sv -----
// decode stage: escape handling, length count and end status per byte
// depends on slip_rx_pkg
module slip_rx_decode #(
  parameter int LENGTH_BITS = slip_rx_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  logic [slip_rx_pkg::BYTE_WIDTH-1:0] raw_byte,
  input  logic [slip_rx_pkg::CFG_WIDTH-1:0] payload_capacity,
  input  logic [slip_rx_pkg::CFG_WIDTH-1:0] max_transfer_unit,
  output logic result_valid,
  output slip_rx_pkg::result_t result,
  output logic [LENGTH_BITS-1:0] length
);

  localparam int CMP_WIDTH =
    (LENGTH_BITS > slip_rx_pkg::CFG_WIDTH) ? LENGTH_BITS : slip_rx_pkg::CFG_WIDTH;
  localparam int EXT_WIDTH =
    (CMP_WIDTH > slip_rx_pkg::POS_WIDTH) ? CMP_WIDTH : slip_rx_pkg::POS_WIDTH;

  logic escape_pending;
  logic escape_pending_next;
  logic [LENGTH_BITS-1:0] length_next;
  logic is_end;
  logic is_esc;
  logic keep;
  logic [CMP_WIDTH-1:0] length_cmp;
  logic [EXT_WIDTH-1:0] length_ext;
  logic [slip_rx_pkg::BYTE_WIDTH-1:0] decoded;
  slip_rx_pkg::status_t end_status;

  assign is_end = (raw_byte == slip_rx_pkg::FRAME_END_CODE);
  assign is_esc = (raw_byte == slip_rx_pkg::ESCAPE_CODE);
  assign length_cmp = CMP_WIDTH'(length);
  assign length_ext = EXT_WIDTH'(length);

  // room for another payload byte: below capacity and below counter limit
  assign keep = (length_cmp < CMP_WIDTH'(payload_capacity)) && (length != '1);

  // translate the byte after an escape
  always_comb begin
    decoded = raw_byte;
    if (escape_pending) begin
      if (raw_byte == slip_rx_pkg::ESCAPED_END_CODE) begin
        decoded = slip_rx_pkg::FRAME_END_CODE;
      end else if (raw_byte == slip_rx_pkg::ESCAPED_ESCAPE_CODE) begin
        decoded = slip_rx_pkg::ESCAPE_CODE;
      end
    end
  end

  // end of frame status
  always_comb begin
    priority if (length == '0) begin
      end_status = slip_rx_pkg::STATUS_EMPTY;
    end else if (length_cmp > CMP_WIDTH'(max_transfer_unit)) begin
      end_status = slip_rx_pkg::STATUS_TOO_LONG;
    end else begin
      end_status = slip_rx_pkg::STATUS_GOOD;
    end
  end

  // result for the current byte
  always_comb begin
    result.byte_position = length_ext[slip_rx_pkg::POS_WIDTH-1:0];
    if (is_end) begin
      result_valid = 1'b1;
      result.data_byte = '0;
      result.frame_end = 1'b1;
      result.frame_status = end_status;
    end else begin
      result_valid = !is_esc && keep;
      result.data_byte = decoded;
      result.frame_end = 1'b0;
      result.frame_status = slip_rx_pkg::STATUS_DATA;
    end
  end

  // next frame state
  always_comb begin
    escape_pending_next = escape_pending;
    length_next = length;
    priority if (is_end) begin
      escape_pending_next = 1'b0;
      length_next = '0;
    end else if (is_esc) begin
      escape_pending_next = 1'b1;
    end else if (keep) begin
      escape_pending_next = 1'b0;
      length_next = length + LENGTH_BITS'(1);
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      length <= '0;
    end else if (advance) begin
      escape_pending <= escape_pending_next;
      length <= length_next;
    end
  end

endmodule

// ----- hw/rtl/slip_rx_out_stage.sv -----
// result register: holds one decoded result until downstream takes it
// depends on slip_rx_pkg
module slip_rx_out_stage (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  slip_rx_pkg::result_t load_result,
  output logic take,
  output logic out_valid,
  input  logic out_ready,
  output slip_rx_pkg::result_t out_result
);

  // free now or emptied at this edge
  assign take = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take && load) begin
      out_result <= load_result;
    end
  end

endmodule

// ----- hw/rtl/slip_rx_top_head.sv -----
// configuration registers of the deframer, written through a plain write port
// depends on slip_rx_pkg
module slip_rx_cfg_regs (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [slip_rx_pkg::INDEX_WIDTH-1:0] cfg_index,
  input  logic [slip_rx_pkg::CFG_WIDTH-1:0] cfg_data,
  output logic [slip_rx_pkg::CFG_WIDTH-1:0] payload_capacity,
  output logic [slip_rx_pkg::CFG_WIDTH-1:0] max_transfer_unit
);

  // register writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_capacity <= slip_rx_pkg::PAYLOAD_CAPACITY_RESET;
      max_transfer_unit <= slip_rx_pkg::MAX_TRANSFER_UNIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        slip_rx_pkg::REG_PAYLOAD_CAPACITY: payload_capacity <= cfg_data;
        slip_rx_pkg::REG_MAX_TRANSFER_UNIT: max_transfer_unit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/slip_receive_deframer.sv -----
// SLIP receive deframer. Takes raw serial bytes on raw_in and gives
// decoded payload bytes with their offset, and one end result per END
// byte with the frame length and status (good, empty, too long), on
// result_out. Bytes past payload_capacity are dropped silently. A byte sits
// in the input register while the decode logic works on it, and its result
// is loaded into the result register when that register can take it; the
// decode stage updates the escape mark and length counter as the byte moves
// on, so the block sustains one byte per cycle while result_out is not
// stalled. The configuration registers reset to 1500; the user must write
// them only while no byte is in flight, which the block does not enforce.
// depends on slip_rx_pkg, slip_rx_if and the slip_rx_* stage modules
module slip_receive_deframer #(
  parameter int LENGTH_BITS = slip_rx_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [slip_rx_pkg::INDEX_WIDTH-1:0] cfg_index,
  input  logic [slip_rx_pkg::CFG_WIDTH-1:0] cfg_data,
  slip_rx_byte_if.sink raw_in,
  slip_rx_result_if.source result_out
);

  logic [slip_rx_pkg::CFG_WIDTH-1:0] payload_capacity;
  logic [slip_rx_pkg::CFG_WIDTH-1:0] max_transfer_unit;
  logic take;
  logic advance;
  logic [slip_rx_pkg::BYTE_WIDTH-1:0] held_byte;
  logic result_valid;
  slip_rx_pkg::result_t result;
  slip_rx_pkg::result_t out_result;
  logic [LENGTH_BITS-1:0] length;

  // configuration registers
  slip_rx_cfg_regs u_cfg (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .payload_capacity  (payload_capacity),
    .max_transfer_unit (max_transfer_unit)
  );

  // input register
  slip_rx_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (raw_in.valid),
    .in_ready  (raw_in.ready),
    .in_byte   (raw_in.raw_byte),
    .take      (take),
    .advance   (advance),
    .held_byte (held_byte)
  );

  // decode stage
  slip_rx_decode #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_decode (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .raw_byte          (held_byte),
    .payload_capacity  (payload_capacity),
    .max_transfer_unit (max_transfer_unit),
    .result_valid      (result_valid),
    .result            (result),
    .length            (length)
  );

  // result register
  slip_rx_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && result_valid),
    .load_result (result),
    .take        (take),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .out_result  (out_result)
  );

  assign result_out.data_byte = out_result.data_byte;
  assign result_out.byte_position = out_result.byte_position;
  assign result_out.frame_end = out_result.frame_end;
  assign result_out.frame_status = out_result.frame_status;

  // an END byte leaves an empty frame behind
  assert property (@(posedge clk) disable iff (rst)
    advance && (held_byte == slip_rx_pkg::FRAME_END_CODE) |=> length == '0)
    else $error("length not cleared after end of frame");

  // a waiting result is never overwritten by the decode stage
  assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.ready |-> !advance)
    else $error("decode advanced while result stalled");

  // end results carry a frame status and a zero byte
  assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.frame_end |->
      result_out.data_byte == '0 &&
      result_out.frame_status != slip_rx_pkg::STATUS_DATA)
    else $error("malformed end result");

  // data results carry the data status
  assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.frame_end |->
      result_out.frame_status == slip_rx_pkg::STATUS_DATA)
    else $error("malformed data result");

endmodule
